### design/rx_ring_buffer_command_framer_defines.svh
// ----------------------------------------------------------------------------
// rx_ring_buffer_command_framer_defines
// Assertion macros shared by the framer's RTL.
// ----------------------------------------------------------------------------
`ifndef RX_RING_BUFFER_COMMAND_FRAMER_DEFINES_SVH
`define RX_RING_BUFFER_COMMAND_FRAMER_DEFINES_SVH

// same-cycle implication
`define RXCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rxcf: same-cycle check failed");

// next-cycle implication
`define RXCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rxcf: next-cycle check failed");

`endif

### design/rxcf_pkg.sv
// ----------------------------------------------------------------------------
// rxcf_pkg
// Types and constants of the receive ring buffer command framer.
// ----------------------------------------------------------------------------
package rxcf_pkg;

  // buffer depth, a power of two
  localparam int DEPTH    = 2048;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int MAX_COPY = 64;
  localparam int LEN_W    = 7;
  localparam int FILL_W   = 11;
  localparam int IDLE_W   = 16;

  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = IDLE_W'(200);
  localparam logic [IDLE_W-1:0] IDLE_MAX         = {IDLE_W{1'b1}};

  typedef logic [PTR_W-1:0] ptr_t;

  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_COPY  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  localparam logic [1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [1:0] CFG_START_SECOND = 2'd1;
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd2;

endpackage

### design/rx_ring_buffer_command_framer.sv
// ----------------------------------------------------------------------------
// rx_ring_buffer_command_framer
// Receive ring buffer with idle flush, command header check and copy-out.
// ----------------------------------------------------------------------------
// Input words (in_*) carry an opcode in tuser: store a received byte, count a
// millisecond tick, check for a command header, or copy bytes out. Each word
// yields one or more result words (out_*), the final one marked by tlast.
// The cfg_* port sets the two start bytes and the idle timeout in ms.
// One word is worked on at a time. Receive, tick, a check with fewer than three
// bytes held and a zero-length copy are answered without leaving the idle state.
// A header check with three or more bytes held makes three reads through the
// single read port of the byte store. A copy issues each byte read while the
// previous byte is sent.
// in_tready is high only with no word in progress and the output register free
// or being taken; a stall on out_tready holds the result and halts the copy.
// Reset clears the pointers, idle count, start bytes and output valid and sets
// the default timeout; the byte store is not cleared; the block is ready at once.
// ----------------------------------------------------------------------------
`include "rx_ring_buffer_command_framer_defines.svh"

module rx_ring_buffer_command_framer
  import rxcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], copy_len[14:8], ascii_mode[15]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_byte[7:0], fill_level[18:8], zero fill
  output logic [2:0]  out_tuser,  // out_valid[0], status[2:1]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK0 = 3'd1;
  localparam logic [2:0] S_CHK1 = 3'd2;
  localparam logic [2:0] S_CHK2 = 3'd3;
  localparam logic [2:0] S_COPY = 3'd4;

  logic [2:0]        state_r, state_nxt;
  ptr_t              rp_r, rp_nxt, wp_r, wp_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt, idle_inc;
  logic [7:0]        start_first_r, start_second_r;
  logic [IDLE_W-1:0] timeout_r;
  logic [LEN_W-1:0]  rem_r, rem_nxt, len_sat;
  logic              ascii_r, ascii_nxt;
  logic              match_r, match_nxt;

  logic              out_tvalid_r;
  logic [7:0]        out_byte_r;
  logic              out_flag_r;
  logic [1:0]        out_status_r;
  logic              out_last_r;
  logic [FILL_W-1:0] out_fill_r;

  logic              emit, e_flag, e_last;
  logic [7:0]        e_byte;
  logic [1:0]        e_status;

  logic              ram_we, ram_re;
  ptr_t              ram_raddr;
  logic [7:0]        ram_rdata;

  logic              acc, out_free;
  ptr_t              held, held_nxt;

  logic [1:0]        opcode;
  logic [7:0]        data_byte;
  logic [LEN_W-1:0]  copy_len;
  logic              ascii_mode;

  assign opcode     = in_tuser;
  assign data_byte  = in_tdata[7:0];
  assign copy_len   = in_tdata[14:8];
  assign ascii_mode = in_tdata[15];

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign held      = wp_r - rp_r;
  assign held_nxt  = wp_nxt - rp_nxt;
  assign idle_inc  = (idle_r != IDLE_MAX) ? idle_r + IDLE_W'(1) : idle_r;
  assign len_sat   = (copy_len > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY) : copy_len;

  rxcf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    idle_nxt  = idle_r;
    rem_nxt   = rem_r;
    ascii_nxt = ascii_r;
    match_nxt = match_r;
    emit      = 1'b0;
    e_byte    = 8'd0;
    e_flag    = 1'b0;
    e_status  = ST_OK;
    e_last    = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rp_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (opcode)
            OP_RX: begin
              emit = 1'b1;
              if (held < ptr_t'(DEPTH - 1)) begin
                ram_we   = 1'b1;
                wp_nxt   = wp_r + ptr_t'(1);
                idle_nxt = '0;
              end else begin
                e_status = ST_DROP;
              end
            end
            OP_TICK: begin
              emit     = 1'b1;
              idle_nxt = idle_inc;
              if (idle_inc > timeout_r) begin
                rp_nxt = wp_r;
              end
            end
            OP_CHECK: begin
              if (held > ptr_t'(2)) begin
                ram_re    = 1'b1;
                state_nxt = S_CHK0;
              end else begin
                emit = 1'b1;
              end
            end
            OP_COPY: begin
              if (len_sat == '0) begin
                emit = 1'b1;
              end else begin
                ram_re    = 1'b1;
                rem_nxt   = len_sat;
                ascii_nxt = ascii_mode;
                state_nxt = S_COPY;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_CHK0: begin
        ram_re    = 1'b1;
        ram_raddr = rp_r + ptr_t'(1);
        match_nxt = (ram_rdata == start_first_r);
        state_nxt = S_CHK1;
      end
      S_CHK1: begin
        ram_re    = 1'b1;
        ram_raddr = rp_r + ptr_t'(2);
        match_nxt = match_r && (ram_rdata == start_second_r);
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (match_r) begin
            e_byte = ram_rdata;
            e_flag = 1'b1;
            rp_nxt = rp_r + ptr_t'(3);
          end
        end
      end
      S_COPY: begin
        if (out_free) begin
          emit = 1'b1;
          if (rp_r == wp_r) begin
            e_status  = ST_SHORT;
            state_nxt = S_IDLE;
          end else begin
            e_byte    = ram_rdata;
            e_flag    = 1'b1;
            rp_nxt    = rp_r + ptr_t'(1);
            ram_re    = 1'b1;
            ram_raddr = rp_r + ptr_t'(1);
            rem_nxt   = rem_r - LEN_W'(1);
            e_last    = (ascii_r && (ram_rdata == 8'd0)) || (rem_r == LEN_W'(1));
            if (e_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      rp_r           <= '0;
      wp_r           <= '0;
      idle_r         <= '0;
      start_first_r  <= '0;
      start_second_r <= '0;
      timeout_r      <= IDLE_TIMEOUT_RST;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      idle_r  <= idle_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_START_FIRST:  start_first_r  <= cfg_wdata[7:0];
          CFG_START_SECOND: start_second_r <= cfg_wdata[7:0];
          CFG_IDLE_TIMEOUT: timeout_r      <= cfg_wdata;
          default: ;
        endcase
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    ascii_r <= ascii_nxt;
    match_r <= match_nxt;
    if (emit) begin
      out_byte_r   <= e_byte;
      out_flag_r   <= e_flag;
      out_status_r <= e_status;
      out_last_r   <= e_last;
      out_fill_r   <= FILL_W'(held_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_fill_r, out_byte_r};
  assign out_tuser  = {out_status_r, out_flag_r};
  assign out_tlast  = out_last_r;

  `RXCF_ASSERT_NEXT(a_accept_progress, acc, out_tvalid_r || (state_r != S_IDLE))
  `RXCF_ASSERT_NOW(a_write_has_room, ram_we, held < ptr_t'(DEPTH - 1))
  `RXCF_ASSERT_NEXT(a_copy_last_ends, (state_r == S_COPY) && emit && e_last, state_r == S_IDLE)
  `RXCF_ASSERT_NOW(a_wp_moves_on_rx, wp_nxt != wp_r, acc && (opcode == OP_RX))

endmodule

### design/rxcf_ram.sv
// ----------------------------------------------------------------------------
// rxcf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rxcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
